// ----- rtl/assert_macros.svh -----
// Assertion macros included by the longest common substring top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising edge of clk_i outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition never holds at a rising edge of clk_i outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/lcs_pkg.sv -----
// Package with request and result types for the longest common substring block.
`default_nettype none

package lcs_pkg;

  localparam int MaxLenDefault = 32;

  typedef struct packed {
    logic       mode;
    logic       has_char;
    logic [7:0] char_code;
    logic       last;
  } lcs_req_t;

  typedef struct packed {
    logic [5:0] match_length;
    logic [4:0] start_first;
    logic [4:0] start_second;
    logic       overflow;
  } lcs_res_t;

endpackage

`default_nettype wire

// ----- rtl/lcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/longest_common_substring.sv -----
// Top level of the longest common substring block: string buffers and diagonal scan sequencer.
// Send the first string as mode 0 requests and the second as mode 1 requests, one character
// each; a request with has_char low stores nothing and sends an empty string. Every request but
// the final one of the second string is taken with busy staying low. The final
// request starts a scan over all F*S character pairs (F, S = stored lengths), diagonal by
// diagonal, one pair per cycle through the single read port of each string buffer and one
// shared compare unit; busy stays high through the scan and the drain state, and the result
// appears on res_o with done_o high for exactly one cycle as busy falls. The receiver cannot
// stall: capture res_o whenever done_o is high. Characters beyond MaxLen per string are
// dropped and reported in the overflow field. After the result both strings are empty again.
`default_nettype none

module longest_common_substring #(
  parameter int MaxLen = lcs_pkg::MaxLenDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire lcs_pkg::lcs_req_t req_i,
  output lcs_pkg::lcs_res_t     res_o,
  output logic                  done_o
);

  import lcs_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = $clog2(MaxLen);
  localparam int LW = $clog2(MaxLen + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [LW-1:0] LenMax = LW'(MaxLen);
  localparam logic [LW-1:0] One    = LW'(1);

  logic [1:0]    state_q, state_d;
  logic [LW-1:0] first_len_q, first_len_d;
  logic [LW-1:0] second_len_q, second_len_d;
  logic          ovf_q, ovf_d;
  logic [LW-1:0] gi_q, gi_d, gj_q, gj_d;
  logic [LW-1:0] di_q, di_d, dj_q, dj_d;
  logic          gnew_q, gnew_d;
  logic          p_valid_q, p_valid_d;
  logic          p_new_q;
  logic [LW-1:0] p_i_q, p_j_q;
  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] best_q, best_d, bi_q, bi_d, bj_q, bj_d;
  logic          done_q, done_d;
  lcs_res_t      res_q, res_d;

  logic          accept;
  logic          we_first, we_second;
  logic [7:0]    rd_first, rd_second;
  logic          gen_ok, step_on, more;
  logic [LW-1:0] ni, nj, nsi, nsj;
  logic [LW-1:0] run, csi, csj;
  logic          better;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign we_first  = accept && !req_i.mode && req_i.has_char && (first_len_q != LenMax);
  assign we_second = accept && req_i.mode && req_i.has_char && (second_len_q != LenMax);

  lcs_ram #(
    .Width(8),
    .Depth(MaxLen)
  ) u_first_ram (
    .clk_i  (clk_i),
    .we_i   (we_first),
    .waddr_i(first_len_q[AW-1:0]),
    .wdata_i(req_i.char_code),
    .raddr_i(gi_q[AW-1:0]),
    .rdata_o(rd_first)
  );

  lcs_ram #(
    .Width(8),
    .Depth(MaxLen)
  ) u_second_ram (
    .clk_i  (clk_i),
    .we_i   (we_second),
    .waddr_i(second_len_q[AW-1:0]),
    .wdata_i(req_i.char_code),
    .raddr_i(gj_q[AW-1:0]),
    .rdata_o(rd_second)
  );

  // Scan address generation.
  always_comb begin
    gen_ok  = (first_len_q != '0) && (second_len_q != '0);
    ni      = gi_q + One;
    nj      = gj_q + One;
    step_on = (ni < first_len_q) && (nj < second_len_q);
    if ((di_q == '0) && ((dj_q + One) < second_len_q)) begin
      nsi = '0;
      nsj = dj_q + One;
    end else if (di_q == '0) begin
      nsi = One;
      nsj = '0;
    end else begin
      nsi = di_q + One;
      nsj = '0;
    end
    more = (nsi < first_len_q);
  end

  // Shared compare unit.
  always_comb begin
    if (rd_first == rd_second) begin
      run = p_new_q ? One : (cur_q + One);
    end else begin
      run = '0;
    end
    csi    = p_i_q + One - run;
    csj    = p_j_q + One - run;
    better = (run > best_q) ||
             ((run == best_q) && (run != '0) &&
              ((csi < bi_q) || ((csi == bi_q) && (csj < bj_q))));
  end

  always_comb begin
    state_d      = state_q;
    first_len_d  = first_len_q;
    second_len_d = second_len_q;
    ovf_d        = ovf_q;
    gi_d         = gi_q;
    gj_d         = gj_q;
    di_d         = di_q;
    dj_d         = dj_q;
    gnew_d       = gnew_q;
    p_valid_d    = 1'b0;
    cur_d        = cur_q;
    best_d       = best_q;
    bi_d         = bi_q;
    bj_d         = bj_q;
    done_d       = 1'b0;
    res_d        = res_q;

    if (p_valid_q) begin
      cur_d = run;
      if (better) begin
        best_d = run;
        bi_d   = csi;
        bj_d   = csj;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.has_char) begin
            if (!req_i.mode) begin
              if (first_len_q != LenMax) begin
                first_len_d = first_len_q + One;
              end else begin
                ovf_d = 1'b1;
              end
            end else begin
              if (second_len_q != LenMax) begin
                second_len_d = second_len_q + One;
              end else begin
                ovf_d = 1'b1;
              end
            end
          end
          if (req_i.mode && req_i.last) begin
            state_d = ST_SCAN;
            gi_d    = '0;
            gj_d    = '0;
            di_d    = '0;
            dj_d    = '0;
            gnew_d  = 1'b1;
            cur_d   = '0;
            best_d  = '0;
            bi_d    = '0;
            bj_d    = '0;
          end
        end
      end
      ST_SCAN: begin
        if (!gen_ok) begin
          state_d = ST_DRAIN;
        end else begin
          p_valid_d = 1'b1;
          if (step_on) begin
            gi_d   = ni;
            gj_d   = nj;
            gnew_d = 1'b0;
          end else if (more) begin
            di_d   = nsi;
            dj_d   = nsj;
            gi_d   = nsi;
            gj_d   = nsj;
            gnew_d = 1'b1;
          end else begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        res_d.match_length = 6'(best_d);
        res_d.start_first  = 5'(bi_d);
        res_d.start_second = 5'(bj_d);
        res_d.overflow     = ovf_q;
        done_d             = 1'b1;
        first_len_d        = '0;
        second_len_d       = '0;
        ovf_d              = 1'b0;
        state_d            = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      first_len_q  <= '0;
      second_len_q <= '0;
      ovf_q        <= 1'b0;
      p_valid_q    <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      first_len_q  <= first_len_d;
      second_len_q <= second_len_d;
      ovf_q        <= ovf_d;
      p_valid_q    <= p_valid_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gi_q    <= gi_d;
    gj_q    <= gj_d;
    di_q    <= di_d;
    dj_q    <= dj_d;
    gnew_q  <= gnew_d;
    p_new_q <= gnew_q;
    p_i_q   <= gi_q;
    p_j_q   <= gj_q;
    cur_q   <= cur_d;
    best_q  <= best_d;
    bi_q    <= bi_d;
    bj_q    <= bj_d;
    res_q   <= res_d;
  end

  assign res_o  = res_q;
  assign done_o = done_q;

  `ASSERT_CLK(a_final_req_busy, (accept && req_i.mode && req_i.last) |=> busy, "final request did not start scan")
  `ASSERT_CLK(a_single_result, done_o |=> !done_o, "result strobe longer than one cycle")
  `ASSERT_NEVER(a_first_len_range, first_len_q > LenMax, "first string length beyond buffer")
  `ASSERT_CLK(a_cell_in_scan, p_valid_q |-> ((state_q == ST_SCAN) || (state_q == ST_DRAIN)), "compare outside scan")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the longest common substring block: directed and random traffic.
`timescale 1ns / 100ps

module tb_top;
  import lcs_pkg::*;

  localparam int MaxLen = MaxLenDefault;
  localparam int ReqBits = $bits(lcs_req_t);
  localparam logic MODE_FIRST = 1'b0;
  localparam logic MODE_SECOND = 1'b1;

  typedef logic [7:0] char_q_t[$];

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  lcs_req_t request;
  lcs_res_t res_o;
  logic done_o;

  // predictor state
  logic [7:0] first_str[MaxLen];
  logic [7:0] second_str[MaxLen];
  int first_cnt;
  int second_cnt;
  bit overflow_seen;

  lcs_res_t pending_matches[$];
  int gap_pct;
  int requests_sent;
  int matches_checked;
  int overflow_results;
  int longest_seen;
  int mismatch_count;

  longest_common_substring DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (request),
    .res_o (res_o),
    .done_o(done_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void absorb_request(lcs_req_t r);
    lcs_res_t res;
    int best;
    int bi;
    int bj;
    int k;
    if (r.has_char) begin
      if (r.mode == MODE_FIRST) begin
        if (first_cnt < MaxLen) begin
          first_str[first_cnt] = r.char_code;
          first_cnt++;
        end else begin
          overflow_seen = 1'b1;
        end
      end else begin
        if (second_cnt < MaxLen) begin
          second_str[second_cnt] = r.char_code;
          second_cnt++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
    end
    if (r.mode == MODE_FIRST || !r.last) return;
    best = 0;
    bi = 0;
    bj = 0;
    for (int i = 0; i < first_cnt; i++) begin
      for (int j = 0; j < second_cnt; j++) begin
        k = 0;
        while (i + k < first_cnt && j + k < second_cnt &&
               first_str[i + k] == second_str[j + k]) k++;
        if (k > best) begin
          best = k;
          bi = i;
          bj = j;
        end
      end
    end
    res.match_length = best[5:0];
    res.start_first = bi[4:0];
    res.start_second = bj[4:0];
    res.overflow = overflow_seen;
    pending_matches = {pending_matches, res};
    first_cnt = 0;
    second_cnt = 0;
    overflow_seen = 1'b0;
  endfunction

  task automatic check_match(lcs_res_t got);
    lcs_res_t want;
    if (pending_matches.size() == 0) begin
      if (mismatch_count < 10)
        $display("unexpected result: len=%0d sf=%0d ss=%0d ovf=%0b",
                 got.match_length, got.start_first, got.start_second, got.overflow);
      mismatch_count++;
      return;
    end
    want = pending_matches.pop_front();
    matches_checked++;
    if (want.overflow) overflow_results++;
    if (int'(want.match_length) > longest_seen) longest_seen = int'(want.match_length);
    if (got.match_length != want.match_length || got.start_first != want.start_first ||
        got.start_second != want.start_second || got.overflow != want.overflow) begin
      if (mismatch_count < 10)
        $display("mismatch: expected len=%0d sf=%0d ss=%0d ovf=%0b,",
                 want.match_length, want.start_first, want.start_second, want.overflow,
                 " got len=%0d sf=%0d ss=%0d ovf=%0b",
                 got.match_length, got.start_first, got.start_second, got.overflow);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) check_match(res_o);
      if (start && !busy) absorb_request(request);
    end
  end

  function automatic lcs_req_t make_req(logic mode, logic has_char, logic [7:0] ch,
                                        logic last);
    lcs_req_t r;
    r.mode = mode;
    r.has_char = has_char;
    r.char_code = ch;
    r.last = last;
    return r;
  endfunction

  task automatic send_request(lcs_req_t r);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk_i); while (busy);
    requests_sent++;
  endtask

  // hold off until every expected result is back
  task automatic drain_matches();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_string(logic mode, char_q_t chars, int split);
    if (chars.size() == 0) begin
      send_request(make_req(mode, 1'b0, 8'($urandom), 1'b1));
      return;
    end
    foreach (chars[n]) begin
      if ($urandom_range(19) == 0) send_request(make_req(mode, 1'b0, 8'($urandom), 1'b0));
      send_request(make_req(mode, 1'b1, chars[n], (n == chars.size() - 1) || (n == split - 1)));
    end
  endtask

  function automatic char_q_t make_word(int len, logic [7:0] pool[4], int pool_n);
    char_q_t w;
    for (int n = 0; n < len; n++)
      w = {w, (pool_n == 0) ? 8'($urandom) : pool[$urandom_range(pool_n - 1)]};
    return w;
  endfunction

  function automatic int pick_len();
    return ($urandom_range(99) < 12) ? $urandom_range(40, 28) : $urandom_range(8);
  endfunction

  task automatic send_random_pair();
    char_q_t a;
    char_q_t b;
    char_q_t piece;
    logic [7:0] pool[4];
    int pool_n;
    int cut;
    int span;
    int split;
    pool_n = ($urandom_range(2) == 0) ? 0 : $urandom_range(4, 2);
    foreach (pool[p]) pool[p] = 8'($urandom);
    a = make_word(pick_len(), pool, pool_n);
    if (a.size() > 0 && $urandom_range(9) < 4) begin
      cut = $urandom_range(a.size() - 1);
      span = $urandom_range(a.size() - cut, 1);
      b = make_word($urandom_range(4), pool, pool_n);
      for (int n = 0; n < span; n++) b = {b, a[cut + n]};
      piece = make_word($urandom_range(4), pool, pool_n);
      b = {b, piece};
    end else begin
      b = make_word(pick_len(), pool, pool_n);
    end
    split = (a.size() > 1 && $urandom_range(9) == 0) ? $urandom_range(a.size() - 1, 1) : 0;
    send_string(MODE_FIRST, a, split);
    send_string(MODE_SECOND, b, 0);
  endtask

  task automatic test_empty_strings();
    send_request(make_req(MODE_FIRST, 1'b0, 8'h00, 1'b1));
    send_request(make_req(MODE_SECOND, 1'b0, 8'hFF, 1'b1));
    send_request(make_req(MODE_FIRST, 1'b1, 8'h41, 1'b1));
    send_request(make_req(MODE_SECOND, 1'b0, 8'h41, 1'b1));
  endtask

  task automatic test_byte_extremes();
    send_request(make_req(MODE_FIRST, 1'b1, 8'h00, 1'b0));
    send_request(make_req(MODE_FIRST, 1'b1, 8'hFF, 1'b1));
    send_request(make_req(MODE_SECOND, 1'b1, 8'hFF, 1'b1));
  endtask

  task automatic test_tie_break();
    send_request(make_req(MODE_FIRST, 1'b1, 8'h61, 1'b0));
    send_request(make_req(MODE_FIRST, 1'b1, 8'h62, 1'b1));
    send_request(make_req(MODE_SECOND, 1'b1, 8'h62, 1'b0));
    send_request(make_req(MODE_SECOND, 1'b1, 8'h61, 1'b1));
  endtask

  task automatic test_split_strings();
    send_request(make_req(MODE_FIRST, 1'b1, 8'h78, 1'b1));
    send_request(make_req(MODE_FIRST, 1'b0, 8'h55, 1'b0));
    send_request(make_req(MODE_FIRST, 1'b1, 8'h79, 1'b1));
    send_request(make_req(MODE_SECOND, 1'b1, 8'h78, 1'b0));
    send_request(make_req(MODE_SECOND, 1'b1, 8'h79, 1'b1));
    send_request(make_req(MODE_SECOND, 1'b1, 8'h71, 1'b0));
    send_request(make_req(MODE_FIRST, 1'b1, 8'h71, 1'b1));
    send_request(make_req(MODE_SECOND, 1'b0, 8'hAA, 1'b1));
  endtask

  task automatic test_random_traffic(int n_items, int pct);
    int target;
    target = requests_sent + n_items;
    gap_pct = pct;
    while (requests_sent < target) begin
      if ($urandom_range(99) < 85) begin
        send_random_pair();
      end else begin
        repeat ($urandom_range(3, 1)) send_request(lcs_req_t'(ReqBits'($urandom)));
      end
    end
    drain_matches();
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    request = '0;
    gap_pct = 0;
    first_cnt = 0;
    second_cnt = 0;
    overflow_seen = 1'b0;
    requests_sent = 0;
    matches_checked = 0;
    overflow_results = 0;
    longest_seen = 0;
    mismatch_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_strings();
    test_byte_extremes();
    test_tie_break();
    test_split_strings();
    drain_matches();
    test_random_traffic(160, 0);
    test_random_traffic(160, 84);
    test_random_traffic(160, 0);
    test_random_traffic(160, 18);

    drain_matches();
    repeat (1100) @(posedge clk_i);
    if (pending_matches.size() != 0) begin
      $display("%0d expected results never arrived", pending_matches.size());
      mismatch_count += pending_matches.size();
    end
    $display("covered %0d requests, %0d results checked, %0d with overflow",
             requests_sent, matches_checked, overflow_results);
    $display("longest match seen %0d, mismatches %0d", longest_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
